@@ sv/cdlr_pkg.sv @@
// ----------------------------------------------------------------------------
// cdlr_pkg
// Shared types, register indexes and the ramp helper for the continuous
// discharge limit ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package cdlr_pkg;

  localparam int CurW   = 14;
  localparam int StepW  = 10;
  localparam int IndexW = 1;
  localparam int DataW  = 14;

  localparam logic [CurW-1:0]  CapReset  = 14'd16383;
  localparam logic [StepW-1:0] StepReset = 10'd5;

  // Configuration register indexes
  localparam logic [IndexW-1:0] RegCurrentCap = 1'b0;
  localparam logic [IndexW-1:0] RegRampStep   = 1'b1;

  // One accepted input item
  typedef struct packed {
    logic [CurW-1:0] table_limit;
    logic            fault_cut_all;
    logic            fault_cut_half;
  } item_t;

  // Ramp state carried from tick to tick
  typedef struct packed {
    logic [CurW-1:0] reported_limit;
    logic [CurW-1:0] ramp_value;
    logic [CurW-1:0] held_target;
    logic            ramping;
    logic            started;
  } ramp_state_t;

  typedef struct packed {
    logic [CurW-1:0] value;
    logic            arrived;
  } approach_t;

  // Move cur one step toward tgt, stopping exactly at tgt.
  function automatic approach_t approach(input logic [CurW-1:0] cur,
                                         input logic [CurW-1:0] tgt,
                                         input logic [StepW-1:0] step);
    logic [CurW:0] up;
    logic [CurW:0] reach;
    approach_t     res;
    up    = {1'b0, cur} + {{(CurW+1-StepW){1'b0}}, step};
    reach = {1'b0, tgt} + {{(CurW+1-StepW){1'b0}}, step};
    if (cur <= tgt) begin
      if (up >= {1'b0, tgt}) begin
        res.value   = tgt;
        res.arrived = 1'b1;
      end else begin
        res.value   = up[CurW-1:0];
        res.arrived = 1'b0;
      end
    end else if ({1'b0, cur} <= reach) begin
      res.value   = tgt;
      res.arrived = 1'b1;
    end else begin
      res.value   = cur - {{(CurW-StepW){1'b0}}, step};
      res.arrived = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/cdlr_step.sv @@
// ----------------------------------------------------------------------------
// cdlr_step
// One tick of the limit: cap, fault derating and slew ramp, giving the
// reported limit and the next ramp state.
// ----------------------------------------------------------------------------
`default_nettype none

module cdlr_step (
  input  cdlr_pkg::item_t                 item,
  input  cdlr_pkg::ramp_state_t           state,
  input  logic [cdlr_pkg::CurW-1:0]       current_cap,
  input  logic [cdlr_pkg::StepW-1:0]      ramp_step,
  output cdlr_pkg::ramp_state_t           state_next,
  output logic [cdlr_pkg::CurW-1:0]       result
);
  import cdlr_pkg::*;

  logic [CurW-1:0] capped;
  logic [CurW-1:0] fault_target;
  logic [CurW-1:0] run_target;
  approach_t       fault_move;
  approach_t       run_move;

  // Cap the table value and pick the derated target
  assign capped       = (item.table_limit >= current_cap) ? current_cap : item.table_limit;
  assign fault_target = item.fault_cut_all ? '0 : {1'b0, capped[CurW-1:1]};
  assign run_target   = state.ramping ? state.held_target : capped;

  assign fault_move = approach(state.reported_limit, fault_target, ramp_step);
  assign run_move   = approach(state.ramp_value, run_target, ramp_step);

  // Select the tick outcome
  always_comb begin
    state_next = state;
    result     = state.ramp_value;
    if (item.fault_cut_all || item.fault_cut_half) begin
      state_next.ramp_value = fault_target;
      state_next.started    = 1'b1;
      result                = fault_move.value;
    end else if (!state.started) begin
      state_next.ramp_value = capped;
      state_next.started    = 1'b1;
      result                = capped;
    end else begin
      state_next.held_target = run_target;
      if (state.ramp_value != run_target) begin
        state_next.ramp_value = run_move.value;
        state_next.ramping    = !run_move.arrived;
        result                = run_move.value;
      end else begin
        state_next.ramping = 1'b0;
        result             = state.ramp_value;
      end
    end
    state_next.reported_limit = result;
  end

endmodule

`default_nettype wire

@@ sv/continuous_discharge_limit_ramp.sv @@
// ----------------------------------------------------------------------------
// continuous_discharge_limit_ramp
// Continuous discharge current limit with cap, fault derating and slew ramp.
// ----------------------------------------------------------------------------
// Each transfer on the input channel yields exactly one discharge_limit
// transfer. An item is registered on entry in the input register and its
// result is then computed into the output register. One item can be taken
// every cycle while the output is not stalled; the ramp state updates in the
// same cycle as the output register, which lets the next item follow directly.
// Stalls on the output hold both stages. Configuration writes take effect at
// once and are meant for idle periods. No clearing pass is needed after reset.
`default_nettype none

module continuous_discharge_limit_ramp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [cdlr_pkg::IndexW-1:0]  cfg_addr,
  input  logic [cdlr_pkg::DataW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cdlr_pkg::CurW-1:0]    table_limit,
  input  logic                         fault_cut_all,
  input  logic                         fault_cut_half,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cdlr_pkg::CurW-1:0]    discharge_limit
);
  import cdlr_pkg::*;

  logic [CurW-1:0]  current_cap;
  logic [StepW-1:0] ramp_step;
  item_t            stage_item;
  logic             stage_valid;
  ramp_state_t      state;
  ramp_state_t      state_next;
  logic [CurW-1:0]  result;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_cap <= CapReset;
      ramp_step   <= StepReset;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        RegCurrentCap: current_cap <= cfg_wdata[CurW-1:0];
        RegRampStep:   ramp_step   <= cfg_wdata[StepW-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake: compute stage moves when the output register is free
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.table_limit    <= table_limit;
      stage_item.fault_cut_all  <= fault_cut_all;
      stage_item.fault_cut_half <= fault_cut_half;
    end
  end

  cdlr_step u_step (
    .item        (stage_item),
    .state       (state),
    .current_cap (current_cap),
    .ramp_step   (ramp_step),
    .state_next  (state_next),
    .result      (result)
  );

  // Ramp state: update once per computed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      discharge_limit <= result;
    end
  end

  // Checks
  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    state.started |=> state.started)
    else $error("started flag cleared");

  a_ramping_needs_start: assert property (@(posedge clk) disable iff (rst)
    state.ramping |-> state.started)
    else $error("ramping before first tick");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_fault_keeps_ramp_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && (stage_item.fault_cut_all || stage_item.fault_cut_half))
      |=> $stable(state.ramping))
    else $error("fault tick changed ramping");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid))
    else $error("result without a staged item");

endmodule

`default_nettype wire

@@ bench/continuous_discharge_limit_ramp_test.sv @@
// ----------------------------------------------------------------------------
// continuous_discharge_limit_ramp_test
// Self-checking bench for the discharge limit ramp. A driver pushes ticks over
// valid/ready with random gaps. Each accepted tick runs through a local model
// of the cap, fault derating and slew ramp. A monitor with random back-pressure
// compares every discharge_limit transfer against the oldest predicted value.
// The cap and step registers are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------

module continuous_discharge_limit_ramp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdlr_pkg::*;

  localparam int PhaseTicks = 190;
  localparam int RandPhases = 10;
  localparam int LongHold   = 300;
  localparam int SettleCyc  = 6;
  localparam int CycleLimit = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [IndexW-1:0] cfg_addr = '0;
  logic [DataW-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CurW-1:0]   table_limit = '0;
  logic              fault_cut_all = 1'b0;
  logic              fault_cut_half = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CurW-1:0]   discharge_limit;

  // Pending ticks and predicted limits
  item_t           tick_q[$];
  logic [CurW-1:0] limit_q[$];
  item_t           offer;

  // Model copy of the configuration and ramp state
  logic [CurW-1:0]  cap_reg = CapReset;
  logic [StepW-1:0] step_reg = StepReset;
  logic [CurW-1:0]  rep_lim = '0;
  logic [15:0]      ramp_val = '0;
  logic [CurW-1:0]  hold_tgt = '0;
  bit               in_ramp = 1'b0;
  bit               seen_first = 1'b0;

  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  continuous_discharge_limit_ramp dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .table_limit    (table_limit),
    .fault_cut_all  (fault_cut_all),
    .fault_cut_half (fault_cut_half),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .discharge_limit(discharge_limit)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR: %s", msg);
  endtask

  // Move cur one step toward tgt, landing exactly on tgt when reached or passed
  function automatic int step_toward(input int cur, input int tgt, output bit hit);
    int s;
    s = int'(step_reg);
    hit = 1'b1;
    if (cur <= tgt) begin
      if (cur + s >= tgt) return tgt;
    end else if (cur <= tgt + s) begin
      return tgt;
    end
    hit = 1'b0;
    return (cur <= tgt) ? cur + s : cur - s;
  endfunction

  // Advance the ramp model by one tick and return the limit it reports
  function automatic logic [CurW-1:0] next_limit(input item_t it);
    int capped;
    int tgt;
    int res;
    bit hit;
    capped = int'(it.table_limit);
    if (capped >= int'(cap_reg)) capped = int'(cap_reg);
    if (it.fault_cut_all || it.fault_cut_half) begin
      // full cut wins over half cut; ramp state is preloaded with the target
      tgt = it.fault_cut_all ? 0 : capped / 2;
      ramp_val = tgt[15:0];
      seen_first = 1'b1;
      res = step_toward(int'(rep_lim), tgt, hit);
    end else if (!seen_first) begin
      ramp_val = capped[15:0];
      seen_first = 1'b1;
      res = capped;
    end else begin
      if (!in_ramp) hold_tgt = capped[CurW-1:0];
      if (ramp_val != hold_tgt) begin
        in_ramp = 1'b1;
        res = step_toward(int'(ramp_val), int'(hold_tgt), hit);
        ramp_val = res[15:0];
        if (hit) in_ramp = 1'b0;
      end else begin
        in_ramp = 1'b0;
      end
      res = int'(ramp_val);
    end
    rep_lim = res[CurW-1:0];
    return rep_lim;
  endfunction

  task automatic queue_tick(input int tl, input bit ca, input bit ch);
    item_t it;
    it.table_limit    = tl[CurW-1:0];
    it.fault_cut_all  = ca;
    it.fault_cut_half = ch;
    tick_q.push_back(it);
  endtask

  // Random tick: mostly steady or drifting levels so ramps can settle
  function automatic item_t make_tick(inout int level);
    item_t it;
    int    pick;
    int    nv;
    int    tl;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      level = $urandom_range(0, 16383);
    end else if (pick < 16) begin
      nv = level + int'($urandom_range(0, 400)) - 200;
      level = (nv < 0) ? 0 : (nv > 16383) ? 16383 : nv;
    end
    tl = (pick >= 94) ? int'($urandom_range(0, 16383)) : level;
    it.table_limit = tl[CurW-1:0];
    pick = $urandom_range(0, 99);
    it.fault_cut_all  = (pick < 7) || (pick >= 95);
    it.fault_cut_half = (pick >= 7 && pick < 20) || (pick >= 95);
    return it;
  endfunction

  // Write both registers; only called while the block is idle
  task automatic set_config(input int cap, input int step);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= RegCurrentCap;
    cfg_wdata <= cap[DataW-1:0];
    cap_reg    = cap[CurW-1:0];
    @(posedge clk);
    cfg_addr  <= RegRampStep;
    cfg_wdata <= {{(DataW-StepW){1'b0}}, step[StepW-1:0]};
    step_reg   = step[StepW-1:0];
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Hold until every tick is taken and every limit has come back
  task automatic wait_idle();
    @(negedge clk);
    while (tick_q.size() > 0 || in_valid || limit_q.size() > 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  // Driver: offer queued ticks, predict on each transfer
  always @(posedge clk) begin : drive_ticks
    logic done;
    logic go;
    done = in_valid && in_ready;
    go   = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (done) limit_q.push_back(next_limit(offer));
      if (!in_valid || done) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tick_q.size() > 0) begin
          offer = tick_q.pop_front();
          go    = 1'b1;
          table_limit    <= offer.table_limit;
          fault_cut_all  <= offer.fault_cut_all;
          fault_cut_half <= offer.fault_cut_half;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end
        in_valid <= go;
      end
    end
  end

  // Monitor: check each limit transfer, apply back-pressure
  always @(posedge clk) begin : watch_limits
    logic [CurW-1:0] want;
    logic            ready_nxt;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (limit_q.size() == 0) begin
          report($sformatf("discharge_limit %0d with nothing expected", discharge_limit));
        end else begin
          want = limit_q.pop_front();
          if (discharge_limit !== want)
            report($sformatf("discharge_limit got %0d expected %0d", discharge_limit, want));
        end
      end
      if (hold_go && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 8);
      end
      out_ready <= ready_nxt;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("continuous_discharge_limit_ramp_test failed");
      $finish;
    end
  end

  initial begin : run_phases
    int level;
    int cap;
    int step;
    item_t it;
    level = 8000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first tick passes through, then fault and ramp corners
    queue_tick(16383, 0, 0);
    queue_tick(0, 0, 0);
    queue_tick(0, 0, 0);
    queue_tick(16383, 1, 1);
    queue_tick(16383, 0, 1);
    queue_tick(16383, 1, 0);
    queue_tick(1, 0, 1);
    queue_tick(16382, 0, 0);
    wait_idle();

    // Zero cap, largest step
    set_config(0, 1023);
    queue_tick(16383, 0, 0);
    queue_tick(12345, 0, 1);
    queue_tick(0, 0, 0);
    wait_idle();

    // Full cap, smallest step
    set_config(16383, 1);
    queue_tick(16383, 0, 0);
    queue_tick(16383, 0, 0);
    queue_tick(8000, 0, 0);
    wait_idle();

    // Frozen step: a running ramp never lands until a fault preloads it
    set_config(16383, 0);
    queue_tick(100, 0, 0);
    queue_tick(200, 0, 1);
    queue_tick(300, 0, 0);
    queue_tick(0, 1, 0);
    wait_idle();

    set_config(16383, 1023);
    queue_tick(16383, 0, 0);
    queue_tick(16383, 0, 0);
    queue_tick(16383, 0, 0);
    wait_idle();

    // Random phases with fresh settings each time
    for (int p = 0; p < RandPhases; p++) begin
      cap  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 16383);
      step = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 1023);
      if (p == 0) cap = 16383;
      if (p == 1) cap = 0;
      if (p == 2) step = 1;
      if (p == 3) step = 1023;
      if (p == RandPhases - 1) calm = 1'b1;
      set_config(cap, step);
      if (p == 4) hold_go = 1'b1;
      for (int k = 0; k < PhaseTicks; k++) begin
        // sender pause halfway through one phase
        if (p == 5 && k == PhaseTicks / 2) wait_idle();
        it = make_tick(level);
        tick_q.push_back(it);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("continuous_discharge_limit_ramp_test passed");
    end else begin
      $display("continuous_discharge_limit_ramp_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cdlr_pkg.sv
sv/cdlr_step.sv
sv/continuous_discharge_limit_ramp.sv
bench/continuous_discharge_limit_ramp_test.sv
